// ----- rtl/vector_direction_quantizer_defines.svh -----
// Assertion macros for the vector direction quantizer.
// No dependencies; included by files that carry concurrent assertions.
`ifndef VECTOR_DIRECTION_QUANTIZER_DEFINES_SVH
`define VECTOR_DIRECTION_QUANTIZER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define VDQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define VDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/vdq_pkg.sv -----
// Shared types, constants and the tangent threshold table of the direction quantizer.
// No dependencies.
`timescale 1ns / 1ps

package vdq_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int TAN_SCALE_SHIFT = 12;   // ratio is scaled by 4096
    localparam int TAN_COUNT       = 64;
    localparam int TAN_BITS        = 19;   // holds the largest threshold plus one
    localparam int IDX_WIDTH       = 7;    // index runs 0..64
    localparam int DIR_WIDTH       = 8;

    localparam logic [DIR_WIDTH-1:0] DIR_ZERO          = 8'd0;
    localparam logic [DIR_WIDTH-1:0] DIR_QUARTER       = 8'd64;
    localparam logic [DIR_WIDTH-1:0] DIR_HALF          = 8'd128;
    localparam logic [DIR_WIDTH-1:0] DIR_THREE_QUARTER = 8'd192;

    // First-quadrant tangent thresholds, scaled by 4096.
    localparam logic [TAN_BITS-1:0] TAN_THRESH [TAN_COUNT] = '{
        19'd50,    19'd151,   19'd252,   19'd353,   19'd454,   19'd556,   19'd659,
        19'd763,   19'd867,   19'd973,   19'd1080,  19'd1188,  19'd1298,  19'd1409,
        19'd1523,  19'd1638,  19'd1756,  19'd1876,  19'd1999,  19'd2125,  19'd2254,
        19'd2387,  19'd2524,  19'd2665,  19'd2810,  19'd2961,  19'd3116,  19'd3278,
        19'd3446,  19'd3622,  19'd3805,  19'd3997,  19'd4198,  19'd4409,  19'd4632,
        19'd4868,  19'd5118,  19'd5383,  19'd5667,  19'd5970,  19'd6296,  19'd6647,
        19'd7028,  19'd7442,  19'd7895,  19'd8392,  19'd8943,  19'd9555,  19'd10242,
        19'd11019, 19'd11906, 19'd12929, 19'd14124, 19'd15540, 19'd17247, 19'd19348,
        19'd22000, 19'd25457, 19'd30158, 19'd36935, 19'd47564, 19'd66670, 19'd111207,
        19'd333752
    };

    // Sign and zero flags of the input vector, carried down the cell row.
    typedef struct packed {
        logic x_neg;
        logic y_neg;
        logic x_zero;
        logic y_zero;
    } t_flags;

endpackage

// ----- rtl/vdq_in_if.sv -----
// Input stream interface: one vector (vec_x, vec_y) per beat.
// Depends on vdq_pkg.
`timescale 1ns / 1ps

interface vdq_in_if
    import vdq_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] vec_x;
    logic signed [COORD_WIDTH-1:0] vec_y;

    modport source (output valid, output vec_x, output vec_y, input ready);
    modport sink   (input valid, input vec_x, input vec_y, output ready);
endinterface

// ----- rtl/vdq_out_if.sv -----
// Output stream interface: one quantized direction per beat.
// Depends on vdq_pkg.
`timescale 1ns / 1ps

interface vdq_out_if
    import vdq_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [DIR_WIDTH-1:0] direction;

    modport source (output valid, output direction, input ready);
    modport sink   (input valid, input direction, output ready);
endinterface

// ----- rtl/vector_direction_quantizer.sv -----
// Vector direction quantizer top: entry stage, row of 64 threshold cells, fold stage.
// Registers on the path of each beat: 1 entry, 64 cells, 1 fold.
// Throughput: one vector per cycle while the sink is ready; each cell holds one beat, empty cells fill under stall.
// Reset: synchronous active-low i_rst_n clears all stage valids; payload is not reset.
// Depends on vdq_pkg, vdq_in_if, vdq_out_if, vdq_front, vdq_cell, vdq_fold.
`timescale 1ns / 1ps
`include "vector_direction_quantizer_defines.svh"

module vector_direction_quantizer
    import vdq_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vdq_in_if.sink     i_in,
    vdq_out_if.source  o_out
);

    logic                   w_valid [TAN_COUNT+1];
    logic                   w_ready [TAN_COUNT+1];
    logic [COORD_WIDTH-1:0] w_ax    [TAN_COUNT+1];
    logic [COORD_WIDTH-1:0] w_ay    [TAN_COUNT+1];
    t_flags                 w_flags [TAN_COUNT+1];
    logic [IDX_WIDTH-1:0]   w_idx   [TAN_COUNT+1];

    // Split the vector into magnitudes and flags.
    vdq_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_vec_x (i_in.vec_x),
        .i_vec_y (i_in.vec_y),
        .o_ready (i_in.ready),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_ax    (w_ax[0]),
        .o_ay    (w_ay[0]),
        .o_flags (w_flags[0])
    );

    assign w_idx[0] = '0;

    // Chain one cell per threshold.
    for (genvar k = 0; k < TAN_COUNT; k++) begin : g_cell
        vdq_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .THRESH_P1   (TAN_THRESH[k] + TAN_BITS'(1))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .i_ax    (w_ax[k]),
            .i_ay    (w_ay[k]),
            .i_flags (w_flags[k]),
            .i_idx   (w_idx[k]),
            .o_ready (w_ready[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_ax    (w_ax[k+1]),
            .o_ay    (w_ay[k+1]),
            .o_flags (w_flags[k+1]),
            .o_idx   (w_idx[k+1])
        );
    end

    // Fold into the quadrant and hold the result for the sink.
    vdq_fold u_fold (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_valid[TAN_COUNT]),
        .i_flags     (w_flags[TAN_COUNT]),
        .i_idx       (w_idx[TAN_COUNT]),
        .o_ready     (w_ready[TAN_COUNT]),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_direction (o_out.direction)
    );

    // An empty output register means the whole row can move.
    `VDQ_ASSERT_NOW(a_empty_out_ready, i_clk, i_rst_n, !o_out.valid, i_in.ready && w_ready[0], "row stalled with empty output register")
    // An accepted beat lands in the entry stage.
    `VDQ_ASSERT_NEXT(a_entry_loaded, i_clk, i_rst_n, i_in.valid && i_in.ready, w_valid[0], "accepted beat lost at entry")
    // A beat leaving the last cell reaches the output register.
    `VDQ_ASSERT_NEXT(a_fold_loaded, i_clk, i_rst_n, w_valid[TAN_COUNT] && w_ready[TAN_COUNT], o_out.valid, "beat lost between last cell and output")

endmodule

// ----- rtl/vdq_front.sv -----
// Entry stage: splits each vector into magnitudes and sign/zero flags.
// Depends on vdq_pkg.
`timescale 1ns / 1ps

module vdq_front
    import vdq_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [COORD_WIDTH-1:0] i_vec_x,
    input  logic [COORD_WIDTH-1:0] i_vec_y,
    output logic                   o_ready,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [COORD_WIDTH-1:0] o_ax,
    output logic [COORD_WIDTH-1:0] o_ay,
    output t_flags                 o_flags
);

    logic                   r_valid;
    logic [COORD_WIDTH-1:0] r_ax;
    logic [COORD_WIDTH-1:0] r_ay;
    t_flags                 r_flags;
    logic [COORD_WIDTH-1:0] n_ax;
    logic [COORD_WIDTH-1:0] n_ay;
    t_flags                 n_flags;

    // Take a beat when the stage is empty or drains this cycle.
    assign o_ready = !r_valid || i_ready;

    // Form magnitudes; the most negative code negates to itself, read as unsigned.
    always_comb begin
        n_flags.x_neg  = i_vec_x[COORD_WIDTH-1];
        n_flags.y_neg  = i_vec_y[COORD_WIDTH-1];
        n_flags.x_zero = (i_vec_x == '0);
        n_flags.y_zero = (i_vec_y == '0);
        n_ax = n_flags.x_neg ? (~i_vec_x + COORD_WIDTH'(1)) : i_vec_x;
        n_ay = n_flags.y_neg ? (~i_vec_y + COORD_WIDTH'(1)) : i_vec_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ax    <= n_ax;
            r_ay    <= n_ay;
            r_flags <= n_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_ax    = r_ax;
    assign o_ay    = r_ay;
    assign o_flags = r_flags;

endmodule

// ----- rtl/vdq_cell.sv -----
// One threshold cell: tests |y|*4096 against (threshold+1)*|x| and counts passes.
// Depends on vdq_pkg.
`timescale 1ns / 1ps

module vdq_cell
    import vdq_pkg::*;
#(
    parameter int                 COORD_WIDTH = COORD_WIDTH_DEF,
    parameter logic [TAN_BITS-1:0] THRESH_P1  = TAN_BITS'(1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [COORD_WIDTH-1:0] i_ax,
    input  logic [COORD_WIDTH-1:0] i_ay,
    input  t_flags                 i_flags,
    input  logic [IDX_WIDTH-1:0]   i_idx,
    output logic                   o_ready,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [COORD_WIDTH-1:0] o_ax,
    output logic [COORD_WIDTH-1:0] o_ay,
    output t_flags                 o_flags,
    output logic [IDX_WIDTH-1:0]   o_idx
);

    localparam int PROD_W = COORD_WIDTH + TAN_BITS;

    logic                   r_valid;
    logic [COORD_WIDTH-1:0] r_ax;
    logic [COORD_WIDTH-1:0] r_ay;
    t_flags                 r_flags;
    logic [IDX_WIDTH-1:0]   r_idx;
    logic [PROD_W-1:0]      w_prod;
    logic [PROD_W-1:0]      w_scaled;
    logic                   w_pass;

    assign o_ready = !r_valid || i_ready;

    // floor(ay*4096/ax) > T  <=>  (T+1)*ax <= ay*4096; thresholds rise, so
    // the pass count equals the index of the first threshold not below the floored ratio.
    assign w_prod   = PROD_W'(i_ax) * PROD_W'(THRESH_P1);
    assign w_scaled = PROD_W'({i_ay, {TAN_SCALE_SHIFT{1'b0}}});
    assign w_pass   = (w_prod <= w_scaled);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Advance the beat to the next cell.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ax    <= i_ax;
            r_ay    <= i_ay;
            r_flags <= i_flags;
            r_idx   <= i_idx + IDX_WIDTH'(w_pass);
        end
    end

    assign o_valid = r_valid;
    assign o_ax    = r_ax;
    assign o_ay    = r_ay;
    assign o_flags = r_flags;
    assign o_idx   = r_idx;

endmodule

// ----- rtl/vdq_fold.sv -----
// Exit stage: folds the first-quadrant index into the vector's quadrant.
// Depends on vdq_pkg; its register is the block's output register.
`timescale 1ns / 1ps

module vdq_fold
    import vdq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_flags               i_flags,
    input  logic [IDX_WIDTH-1:0] i_idx,
    output logic                 o_ready,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [DIR_WIDTH-1:0] o_direction
);

    logic                 r_valid;
    logic [DIR_WIDTH-1:0] r_direction;
    logic [DIR_WIDTH-1:0] n_direction;
    logic [DIR_WIDTH-1:0] w_idx;

    assign o_ready = !r_valid || i_ready;
    assign w_idx   = DIR_WIDTH'(i_idx);

    // Pick the direction; the axis case ignores the index.
    always_comb begin
        priority if (i_flags.x_zero) begin
            priority if (i_flags.y_zero) begin
                n_direction = DIR_ZERO;
            end else if (i_flags.y_neg) begin
                n_direction = DIR_THREE_QUARTER;
            end else begin
                n_direction = DIR_QUARTER;
            end
        end else if (i_flags.x_neg) begin
            n_direction = i_flags.y_neg ? (DIR_HALF + w_idx) : (DIR_HALF - w_idx);
        end else if (i_flags.y_neg) begin
            // wraps to zero for a zero index
            n_direction = DIR_ZERO - w_idx;
        end else begin
            n_direction = w_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_direction <= n_direction;
        end
    end

    assign o_valid     = r_valid;
    assign o_direction = r_direction;

endmodule
